// ===== hw/rtl/integer_to_roman_numeral_macros.svh =====
// Assertion macros used by integer_to_roman_numeral.sv.
`ifndef INTEGER_TO_ROMAN_NUMERAL_MACROS_SVH
`define INTEGER_TO_ROMAN_NUMERAL_MACROS_SVH

// Clocked check, off while reset is asserted.
`define I2R_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define I2R_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/i2r_pkg.sv =====
package i2r_pkg;

    localparam int VALUE_W   = 12;
    localparam int SYMBOL_W  = 7;
    localparam int DIGIT_W   = 4;
    localparam int POS_W     = 2;
    localparam int PAT_W     = 2;
    localparam int LEN_W     = 3;
    localparam int WEIGHT_W  = 10;
    localparam int PRODUCT_W = 14;

    localparam logic [VALUE_W-1:0] MAX_VALUE = 12'd2999;

    localparam logic [SYMBOL_W-1:0] SYM_I = 7'h49;
    localparam logic [SYMBOL_W-1:0] SYM_V = 7'h56;
    localparam logic [SYMBOL_W-1:0] SYM_X = 7'h58;
    localparam logic [SYMBOL_W-1:0] SYM_L = 7'h4C;
    localparam logic [SYMBOL_W-1:0] SYM_C = 7'h43;
    localparam logic [SYMBOL_W-1:0] SYM_D = 7'h44;
    localparam logic [SYMBOL_W-1:0] SYM_M = 7'h4D;

    // Program steps of the sequencer.
    typedef enum logic [1:0] {
        STEP_IDLE,
        STEP_EXTRACT,
        STEP_EMIT,
        STEP_ERROR
    } step_t;

    // Micro-operations that drive the datapath.
    typedef enum logic [1:0] {
        UOP_LOAD,
        UOP_EXTRACT,
        UOP_EMIT,
        UOP_ERROR
    } uop_t;

    // One control word: operation, fall-through step, conditional jump target.
    typedef struct packed {
        uop_t  op;
        step_t seq;
        step_t jump;
    } uword_t;

    // Symbol class within a digit pattern.
    typedef enum logic [1:0] {
        CLS_ONE,
        CLS_FIVE,
        CLS_TEN
    } cls_t;

    // Microcode ROM. Jumps: LOAD on a bad value, EMIT after the ones digit.
    function automatic uword_t ucode(step_t s);
        uword_t w;
        case (s)
            STEP_IDLE:    w = '{op: UOP_LOAD,    seq: STEP_EXTRACT, jump: STEP_ERROR};
            STEP_EXTRACT: w = '{op: UOP_EXTRACT, seq: STEP_EMIT,    jump: STEP_EMIT};
            STEP_EMIT:    w = '{op: UOP_EMIT,    seq: STEP_EXTRACT, jump: STEP_IDLE};
            STEP_ERROR:   w = '{op: UOP_ERROR,   seq: STEP_IDLE,    jump: STEP_IDLE};
            default:      w = '{op: UOP_LOAD,    seq: STEP_IDLE,    jump: STEP_IDLE};
        endcase
        return w;
    endfunction

    // Decimal weight of a digit position (0 = ones).
    function automatic logic [WEIGHT_W-1:0] digit_weight(logic [POS_W-1:0] pos);
        logic [WEIGHT_W-1:0] w;
        case (pos)
            2'd0:    w = 10'd1;
            2'd1:    w = 10'd10;
            2'd2:    w = 10'd100;
            default: w = 10'd1000;
        endcase
        return w;
    endfunction

    // Number of characters in the pattern of a digit.
    function automatic logic [LEN_W-1:0] pattern_len(logic [DIGIT_W-1:0] d);
        logic [LEN_W-1:0] n;
        case (d)
            4'd1, 4'd5:       n = 3'd1;
            4'd2, 4'd4, 4'd6,
            4'd9:             n = 3'd2;
            4'd3, 4'd7:       n = 3'd3;
            4'd8:             n = 3'd4;
            default:          n = 3'd0;
        endcase
        return n;
    endfunction

    // Symbol class at one place of a digit pattern.
    function automatic cls_t pattern_cls(logic [DIGIT_W-1:0] d, logic [PAT_W-1:0] idx);
        cls_t c;
        case (d)
            4'd4:                   c = (idx == '0) ? CLS_ONE : CLS_FIVE;
            4'd9:                   c = (idx == '0) ? CLS_ONE : CLS_TEN;
            4'd5, 4'd6, 4'd7, 4'd8: c = (idx == '0) ? CLS_FIVE : CLS_ONE;
            default:                c = CLS_ONE;
        endcase
        return c;
    endfunction

    // ASCII code for a symbol class at a digit position.
    function automatic logic [SYMBOL_W-1:0] numeral_char(logic [POS_W-1:0] pos, cls_t c);
        logic [SYMBOL_W-1:0] s;
        case ({pos, c})
            {2'd0, CLS_ONE}:  s = SYM_I;
            {2'd0, CLS_FIVE}: s = SYM_V;
            {2'd0, CLS_TEN}:  s = SYM_X;
            {2'd1, CLS_ONE}:  s = SYM_X;
            {2'd1, CLS_FIVE}: s = SYM_L;
            {2'd1, CLS_TEN}:  s = SYM_C;
            {2'd2, CLS_ONE}:  s = SYM_C;
            {2'd2, CLS_FIVE}: s = SYM_D;
            {2'd2, CLS_TEN}:  s = SYM_M;
            {2'd3, CLS_ONE}:  s = SYM_M;
            default:          s = '0;
        endcase
        return s;
    endfunction

endpackage

// ===== hw/rtl/integer_to_roman_numeral.sv =====
// Roman numeral encoder: each value accepted on the slave stream comes out on the master
// stream as its numeral in ASCII, most significant character first, tlast on the final
// character. Values 1 to 2999 are converted; zero or anything above 2999 gives a single
// transfer with tuser (error) set, symbol zero and tlast set. A small microcoded sequencer
// walks the thousands, hundreds, tens and ones digits: an extract step peels a digit off the
// remainder, then its pattern leaves one character per cycle unless the output is held by
// backpressure (a zero digit leaves no character). A new value is accepted only in the idle
// step, while the last character may still sit in the output register.
`include "integer_to_roman_numeral_macros.svh"

module integer_to_roman_numeral (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] value, [15:12] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [6:0] symbol, [7] zero
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // [0] error
);
    import i2r_pkg::*;

    step_t                 step_reg, step_next;
    uword_t                uw;

    logic [VALUE_W-1:0]    rem_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [DIGIT_W-1:0]    digit_reg;
    logic [PAT_W-1:0]      pat_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [SYMBOL_W-1:0]   out_symbol_reg;
    logic                  out_last_reg;
    logic                  out_error_reg;

    logic [VALUE_W-1:0]    in_value;
    logic                  in_fire;
    logic                  value_bad;
    logic                  out_free;
    logic [WEIGHT_W-1:0]   weight;
    logic [DIGIT_W-1:0]    ext_digit;
    logic [VALUE_W-1:0]    ext_sub;
    logic [LEN_W-1:0]      pat_len;
    logic                  pat_last;
    logic                  digit_done;
    logic                  emit_char;
    logic                  emit_err;
    logic [SYMBOL_W-1:0]   char_code;

    assign uw        = ucode(step_reg);
    assign in_value  = s_axis_tdata[VALUE_W-1:0];
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign value_bad = (in_value == '0) || (in_value > MAX_VALUE);
    assign out_free  = !out_valid_reg || m_axis_tready;

    // Peel the leading digit off the remainder at the current position.
    assign weight = digit_weight(pos_reg);

    always_comb
    begin
        ext_digit = '0;
        ext_sub   = '0;
        for (int k = 1; k <= 9; k++)
        begin
            if ({2'b00, rem_reg} >= PRODUCT_W'(k) * PRODUCT_W'(weight))
            begin
                ext_digit = DIGIT_W'(k);
                ext_sub   = VALUE_W'(PRODUCT_W'(k) * PRODUCT_W'(weight));
            end
        end
    end

    assign pat_len    = pattern_len(digit_reg);
    assign pat_last   = ({1'b0, pat_reg} == (pat_len - 3'd1));
    assign char_code  = numeral_char(pos_reg, pattern_cls(digit_reg, pat_reg));
    assign digit_done = (pat_len == '0) || (out_free && pat_last);

    // Next step of the program.
    always_comb
    begin
        step_next = step_reg;
        case (uw.op)
            UOP_LOAD:
            begin
                if (in_fire)
                    step_next = value_bad ? uw.jump : uw.seq;
            end
            UOP_EXTRACT:
                step_next = uw.seq;
            UOP_EMIT:
            begin
                if (digit_done)
                    step_next = (pos_reg == '0) ? uw.jump : uw.seq;
            end
            UOP_ERROR:
            begin
                if (out_free)
                    step_next = uw.seq;
            end
            default:
                step_next = STEP_IDLE;
        endcase
    end

    // Control outputs of the current control word.
    always_comb
    begin
        s_axis_tready = 1'b0;
        emit_char     = 1'b0;
        emit_err      = 1'b0;
        case (uw.op)
            UOP_LOAD:    s_axis_tready = 1'b1;
            UOP_EMIT:    emit_char     = out_free && (pat_len != '0);
            UOP_ERROR:   emit_err      = out_free;
            default:     ;
        endcase
    end

    always_comb
    begin
        if (emit_char || emit_err)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_IDLE;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            pat_reg       <= '0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (in_fire)
                pos_reg <= POS_W'(3);
            else if (uw.op == UOP_EMIT && digit_done && pos_reg != '0)
                pos_reg <= pos_reg - 1'b1;
            if (uw.op == UOP_EXTRACT)
                pat_reg <= '0;
            else if (emit_char)
                pat_reg <= pat_reg + 1'b1;
        end
    end

    // Datapath payload.
    always_ff @(posedge clk)
    begin
        if (in_fire)
            rem_reg <= in_value;
        else if (uw.op == UOP_EXTRACT)
            rem_reg <= rem_reg - ext_sub;
        if (uw.op == UOP_EXTRACT)
            digit_reg <= ext_digit;
        // Remainder is already stripped of this digit, so zero means nothing follows.
        if (emit_char)
        begin
            out_symbol_reg <= char_code;
            out_last_reg   <= pat_last && (rem_reg == '0);
            out_error_reg  <= 1'b0;
        end
        else if (emit_err)
        begin
            out_symbol_reg <= '0;
            out_last_reg   <= 1'b1;
            out_error_reg  <= 1'b1;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_symbol_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_error_reg;

    `I2R_ASSERT(a_bad_goes_error, (in_fire && value_bad) |=> (step_reg == STEP_ERROR), "bad value did not branch to error step")
    `I2R_ASSERT(a_error_shape, (out_valid_reg && out_error_reg) |-> (out_last_reg && out_symbol_reg == '0), "error transfer malformed")
    `I2R_ASSERT(a_char_nonzero, (out_valid_reg && !out_error_reg) |-> (out_symbol_reg != '0), "numeral transfer with empty symbol")
    `I2R_ASSERT(a_rem_in_range, (step_reg == STEP_EXTRACT) |-> ({2'b00, rem_reg} < PRODUCT_W'(10) * PRODUCT_W'(weight)), "remainder exceeds digit range")
    `I2R_ASSERT(a_thousands_max, (step_reg == STEP_EMIT && pos_reg == 2'd3) |-> (digit_reg <= 4'd2), "thousands digit above two")
    `I2R_ASSERT_ALWAYS(a_no_out_in_reset, !rst_n |=> !out_valid_reg || rst_n, "output valid out of reset")

endmodule
